>>> design/rit_pkg.sv
// Shared constants, command type and register indexes of the RGB image transpose core.
`default_nettype none

package rit_pkg;

    localparam int MAX_DIM     = 256;
    localparam int MAX_PIXELS  = 65536;

    localparam int DIM_W       = $clog2(MAX_DIM) + 1;
    localparam int COORD_W     = $clog2(MAX_DIM);
    localparam int ADDR_W      = $clog2(MAX_PIXELS);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int CHAN_W      = 8;
    localparam int PIX_W       = 3 * CHAN_W;
    localparam int CFG_IDX_W   = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = QUEUE_AW + 1;

    localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(MAX_DIM);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_FETCH = 1'b1;

    typedef struct packed {
        logic              is_read;
        logic              last;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } t_cmd;

endpackage

`default_nettype wire

>>> design/rit_if.sv
// Channel interfaces of the RGB image transpose core: configuration, pixel in, pixel out.
`default_nettype none

interface rit_cfg_if import rit_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [DIM_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

interface rit_pix_in_if import rit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, output action, output red_in, output green_in,
                    output blue_in, input ready);
    modport sink (input valid, input action, input red_in, input green_in,
                  input blue_in, output ready);
endinterface

interface rit_pix_out_if import rit_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic              last_pixel;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output last_pixel, input ready);
    modport sink (input valid, input red_out, input green_out, input blue_out,
                  input last_pixel, output ready);
endinterface

`default_nettype wire

>>> design/rit_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none

module rit_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output      logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

>>> design/rit_front.sv
// Front end: configuration registers, frame counters and command issue.
`default_nettype none

module rit_front import rit_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rit_cfg_if.sink     i_cfg,
    rit_pix_in_if.sink  i_pix,
    input  wire logic   i_queue_full,
    output      logic   o_push,
    output      t_cmd   o_cmd
);

    logic [DIM_W-1:0]   r_image_width;
    logic [DIM_W-1:0]   r_image_height;
    logic [COUNT_W-1:0] r_count, n_count;
    logic [COORD_W-1:0] r_col, n_col;
    logic [COORD_W-1:0] r_row, n_row;
    logic               r_full, n_full;

    logic [DIM_W-1:0]     w_dim;
    logic [DIM_W-1:0]     h_dim;
    logic [2*DIM_W-1:0]   total_prod;
    logic [COUNT_W-1:0]   total;
    logic [COORD_W+DIM_W-1:0] row_base;
    logic [COORD_W+DIM_W-1:0] rd_addr_full;
    logic                 accept;
    logic                 row_wrap;
    logic                 col_wrap;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] res;
        res = v;
        if (v == '0) begin
            res = DIM_W'(1);
        end else if (v > DIM_RESET) begin
            res = DIM_RESET;
        end
        return res;
    endfunction

    assign w_dim        = clamp_dim(r_image_width);
    assign h_dim        = clamp_dim(r_image_height);
    assign total_prod   = w_dim * h_dim;
    assign total        = total_prod[COUNT_W-1:0];
    assign row_base     = r_row * w_dim;
    assign rd_addr_full = row_base + (COORD_W+DIM_W)'(r_col);
    assign row_wrap     = ({1'b0, r_row} + DIM_W'(1)) >= h_dim;
    assign col_wrap     = ({1'b0, r_col} + DIM_W'(1)) >= w_dim;

    assign i_cfg.ready  = 1'b1;
    assign i_pix.ready  = !i_queue_full;
    assign accept       = i_pix.valid && !i_queue_full;

    always_comb begin
        n_count     = r_count;
        n_col       = r_col;
        n_row       = r_row;
        n_full      = r_full;
        o_push      = 1'b0;
        o_cmd.is_read = 1'b0;
        o_cmd.last  = 1'b0;
        o_cmd.addr  = r_count[ADDR_W-1:0];
        o_cmd.pix   = {i_pix.red_in, i_pix.green_in, i_pix.blue_in};
        if (accept) begin
            unique case (i_pix.action)
                ACT_LOAD: begin
                    if (!r_full) begin
                        o_push = !r_count[COUNT_W-1];
                        if (r_count < total) begin
                            n_count = r_count + COUNT_W'(1);
                        end
                        if (n_count >= total) begin
                            n_full = 1'b1;
                            n_col  = '0;
                            n_row  = '0;
                        end
                    end
                end
                ACT_FETCH: begin
                    if (r_full) begin
                        o_push        = 1'b1;
                        o_cmd.is_read = 1'b1;
                        o_cmd.addr    = rd_addr_full[ADDR_W-1:0];
                        if (row_wrap) begin
                            n_row = '0;
                            if (col_wrap) begin
                                o_cmd.last = 1'b1;
                                n_col      = '0;
                                n_full     = 1'b0;
                                n_count    = '0;
                            end else begin
                                n_col = r_col + COORD_W'(1);
                            end
                        end else begin
                            n_row = r_row + COORD_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= DIM_RESET;
            r_image_height <= DIM_RESET;
            r_count        <= '0;
            r_col          <= '0;
            r_row          <= '0;
            r_full         <= 1'b0;
        end else begin
            r_count <= n_count;
            r_col   <= n_col;
            r_row   <= n_row;
            r_full  <= n_full;
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_IMAGE_WIDTH:  r_image_width  <= i_cfg.data;
                    REG_IMAGE_HEIGHT: r_image_height <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> design/rit_queue.sv
// Command queue between front end and back end.
`default_nettype none

module rit_queue import rit_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output      logic o_valid,
    output      logic o_full,
    output      t_cmd o_cmd
);

    t_cmd                r_entries [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_CW-1:0] r_count;
    logic                do_pop;

    assign o_valid = r_count != '0;
    assign o_full  = r_count == QUEUE_CW'(QUEUE_DEPTH);
    assign o_cmd   = r_entries[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entries[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QUEUE_CW'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - QUEUE_CW'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || do_pop))
        else $error("command pushed into full queue");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QUEUE_CW'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

`default_nettype wire

>>> design/rit_back.sv
// Back end: frame store writes, transposed reads and the output register.
`default_nettype none

module rit_back import rit_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_cmd_valid,
    input  wire t_cmd     i_cmd,
    output      logic     o_pop,
    rit_pix_out_if.source o_pix
);

    logic             r_pend;
    logic             r_pend_last;
    logic             r_out_valid;
    logic             r_out_last;
    logic [PIX_W-1:0] r_out_pix;
    logic [PIX_W-1:0] rd_data;
    logic             advance;
    logic             wr_en;
    logic             rd_en;

    assign advance = r_pend && (!r_out_valid || o_pix.ready);
    assign o_pop   = i_cmd_valid && (!i_cmd.is_read || !r_pend || advance);
    assign wr_en   = o_pop && !i_cmd.is_read;
    assign rd_en   = o_pop && i_cmd.is_read;

    rit_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_PIXELS)
    ) u_frame_store (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (i_cmd.addr),
        .i_wr_data (i_cmd.pix),
        .i_rd_en   (rd_en),
        .i_rd_addr (i_cmd.addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (rd_en) begin
                r_pend <= 1'b1;
            end else if (advance) begin
                r_pend <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_pend_last <= i_cmd.last;
        end
        if (advance) begin
            r_out_pix  <= rd_data;
            r_out_last <= r_pend_last;
        end
    end

    assign o_pix.valid      = r_out_valid;
    assign o_pix.red_out    = r_out_pix[PIX_W-1 -: CHAN_W];
    assign o_pix.green_out  = r_out_pix[2*CHAN_W-1 -: CHAN_W];
    assign o_pix.blue_out   = r_out_pix[CHAN_W-1:0];
    assign o_pix.last_pixel = r_out_last;

    a_pend_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pend && !advance) |=> r_pend)
        else $error("pending read lost while output stalled");

    a_read_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_en |-> (!r_pend || advance))
        else $error("read issued over a pending read");

endmodule

`default_nettype wire

>>> design/rgb_image_transpose_core.sv
// Top level of the RGB image transpose core.
// Fetches pass the queue, store read and output registers; loads give no result.
// Throughput: one item per cycle on load and drain unless the output stalls, set by the
// single-port-per-cycle frame store and the four-entry front-to-back command queue.
// Reset: counters, queue and output clear, both dimension registers return to 256;
// frame store contents are undefined until written and are not cleared.
`default_nettype none

module rgb_image_transpose_core import rit_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rit_cfg_if.sink       i_cfg,
    rit_pix_in_if.sink    i_pix,
    rit_pix_out_if.source o_pix
);

    logic push;
    logic pop;
    logic queue_valid;
    logic queue_full;
    t_cmd push_cmd;
    t_cmd pop_cmd;

    rit_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .i_pix        (i_pix),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    rit_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_full  (queue_full),
        .o_cmd   (pop_cmd)
    );

    rit_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (queue_valid),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_pix       (o_pix)
    );

endmodule

`default_nettype wire

>>> tb/rgb_image_transpose_checker.sv
`timescale 1ns / 1ps
// Checker for the RGB image transpose core: predicts transposed pixels and scores the output.
module rgb_image_transpose_checker import rit_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rit_cfg_if     i_cfg,
    rit_pix_in_if  i_pix_in,
    rit_pix_out_if i_pix_out,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked
);

    localparam int MAX_REPORTS = 40;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              last;
    } t_pixel_result;

    logic [PIX_W-1:0]   frame_mem [MAX_PIXELS];
    logic [DIM_W-1:0]   width_reg;
    logic [DIM_W-1:0]   height_reg;
    logic [COUNT_W-1:0] stored_count;
    logic [COORD_W-1:0] col_pos;
    logic [COORD_W-1:0] row_pos;
    logic               frame_ready;
    t_pixel_result      transposed_q[$];
    int                 fail_total;
    int                 checked_total;

    function automatic int effective_dim(input logic [DIM_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    task automatic predict_transfer(input logic act, input logic [PIX_W-1:0] pix_in);
        int               eff_w;
        int               eff_h;
        int               addr;
        logic [PIX_W-1:0] pix_rd;
        t_pixel_result    res;
        begin
            eff_w = effective_dim(width_reg);
            eff_h = effective_dim(height_reg);
            if (act == ACT_LOAD) begin
                if (!frame_ready) begin
                    if (stored_count < MAX_PIXELS) frame_mem[stored_count[ADDR_W-1:0]] = pix_in;
                    if (stored_count < eff_w * eff_h) stored_count = stored_count + 1'b1;
                    if (stored_count >= eff_w * eff_h) begin
                        frame_ready = 1'b1;
                        col_pos     = '0;
                        row_pos     = '0;
                    end
                end
            end else if (frame_ready) begin
                addr     = int'(row_pos) * eff_w + int'(col_pos);
                pix_rd   = (addr < MAX_PIXELS) ? frame_mem[addr] : '0;
                res.last = 1'b0;
                if (int'(row_pos) + 1 >= eff_h) begin
                    row_pos = '0;
                    if (int'(col_pos) + 1 >= eff_w) begin
                        res.last = 1'b1;
                        col_pos  = '0;
                    end else begin
                        col_pos = col_pos + 1'b1;
                    end
                end else begin
                    row_pos = row_pos + 1'b1;
                end
                if (res.last) begin
                    frame_ready  = 1'b0;
                    stored_count = '0;
                end
                {res.red, res.green, res.blue} = pix_rd;
                transposed_q.push_back(res);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [CHAN_W-1:0] want,
                               input logic [CHAN_W-1:0] got);
        begin
            if (got !== want) begin
                if (fail_total < MAX_REPORTS)
                    $display("%0t: %s mismatch, expected %02h, got %02h", $time, name, want, got);
                fail_total++;
            end
        end
    endtask

    initial begin
        fail_total    = 0;
        checked_total = 0;
    end

    always @(posedge i_clk) begin
        t_pixel_result want;
        if (!i_rst_n) begin
            width_reg    = DIM_RESET;
            height_reg   = DIM_RESET;
            stored_count = '0;
            col_pos      = '0;
            row_pos      = '0;
            frame_ready  = 1'b0;
            transposed_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    REG_IMAGE_WIDTH: width_reg = i_cfg.data;
                    REG_IMAGE_HEIGHT: height_reg = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_pix_in.valid && i_pix_in.ready)
                predict_transfer(i_pix_in.action,
                                 {i_pix_in.red_in, i_pix_in.green_in, i_pix_in.blue_in});
            if (i_pix_out.valid && i_pix_out.ready) begin
                if (transposed_q.size() == 0) begin
                    if (fail_total < MAX_REPORTS)
                        $display("%0t: unexpected pixel, expected none, got %02h %02h %02h last %0b",
                                 $time, i_pix_out.red_out, i_pix_out.green_out,
                                 i_pix_out.blue_out, i_pix_out.last_pixel);
                    fail_total++;
                end else begin
                    want = transposed_q.pop_front();
                    check_field("red_out", want.red, i_pix_out.red_out);
                    check_field("green_out", want.green, i_pix_out.green_out);
                    check_field("blue_out", want.blue, i_pix_out.blue_out);
                    check_field("last_pixel", {7'b0, want.last}, {7'b0, i_pix_out.last_pixel});
                    checked_total++;
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= transposed_q.size();
        o_checked    <= checked_total;
    end

endmodule

>>> tb/rgb_image_transpose_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the RGB image transpose core: stimulus, handshake pacing and verdict.
module rgb_image_transpose_core_tb;
    import rit_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYC    = 12;
    localparam int SETTLE_CYC   = 8;
    localparam int HOLD_CYC     = 300;
    localparam int STREAM_ITEMS = 900;
    localparam int QUIET_ITEMS  = 150;

    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = CFG_IDX_W'(3);

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic quiet_end;
    logic hold_req;
    logic hold_done;
    int   idle_pct;
    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   sent_items;
    int   stream_items;
    int   frames_done;

    rit_cfg_if     cfg_if ();
    rit_pix_in_if  pix_in_if ();
    rit_pix_out_if pix_out_if ();

    rgb_image_transpose_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if),
        .i_pix   (pix_in_if),
        .o_pix   (pix_out_if)
    );

    rgb_image_transpose_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg_if),
        .i_pix_in     (pix_in_if),
        .i_pix_out    (pix_out_if),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("Timeout with %0d pixels still outstanding", pending_count);
        $display("Some tests failed");
        $finish;
    end

    // output side: random stalls, long hold-off on request
    initial begin
        pix_out_if.ready = 1'b0;
        hold_done        = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                pix_out_if.ready = 1'b0;
                repeat (HOLD_CYC) @(negedge i_clk);
                hold_done = 1'b1;
            end else if (!quiet_end && $urandom_range(1, 100) <= idle_pct) begin
                pix_out_if.ready = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end else begin
                pix_out_if.ready = 1'b1;
            end
        end
    end

    task automatic send_pixel(input logic act, input logic [CHAN_W-1:0] r,
                              input logic [CHAN_W-1:0] g, input logic [CHAN_W-1:0] b);
        begin
            if (!quiet_end && $urandom_range(1, 100) <= idle_pct) begin
                @(negedge i_clk);
                pix_in_if.valid = 1'b0;
                repeat ($urandom_range(0, 3)) @(negedge i_clk);
            end
            @(negedge i_clk);
            pix_in_if.valid    = 1'b1;
            pix_in_if.action   = act;
            pix_in_if.red_in   = r;
            pix_in_if.green_in = g;
            pix_in_if.blue_in  = b;
            do @(posedge i_clk); while (!pix_in_if.ready);
            sent_items++;
        end
    endtask

    task automatic send_random(input logic act);
        begin
            send_pixel(act, CHAN_W'($urandom_range(0, 255)), CHAN_W'($urandom_range(0, 255)),
                       CHAN_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_idle;
        begin
            @(negedge i_clk);
            pix_in_if.valid = 1'b0;
            wait (pending_count == 0);
            repeat (SETTLE_CYC) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
        begin
            @(negedge i_clk);
            cfg_if.valid = 1'b1;
            cfg_if.index = idx;
            cfg_if.data  = value;
            do @(posedge i_clk); while (!cfg_if.ready);
            @(negedge i_clk);
            cfg_if.valid = 1'b0;
        end
    endtask

    task automatic run_frame(input logic [DIM_W-1:0] w_raw, input logic [DIM_W-1:0] h_raw,
                             input bit reconfigure, input bit with_hold);
        int total;
        begin
            total = ((w_raw == '0) ? 1 : (w_raw > MAX_DIM) ? MAX_DIM : int'(w_raw)) *
                    ((h_raw == '0) ? 1 : (h_raw > MAX_DIM) ? MAX_DIM : int'(h_raw));
            idle_pct = (with_hold || quiet_end) ? 0 : 25 * $urandom_range(0, 2);
            if (reconfigure) begin
                wait_idle();
                write_reg(REG_IMAGE_WIDTH, w_raw);
                write_reg(REG_IMAGE_HEIGHT, h_raw);
            end
            for (int i = 0; i < total; i++) begin
                if ($urandom_range(0, 11) == 0) send_random(ACT_FETCH);
                send_random(ACT_LOAD);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 3)) send_random(ACT_LOAD);
            if (with_hold) hold_req = 1'b1;
            for (int i = 0; i < total; i++) send_random(ACT_FETCH);
            stream_items += 2 * total;
            frames_done++;
        end
    endtask

    initial begin
        logic [DIM_W-1:0] w_sel;
        logic [DIM_W-1:0] h_sel;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = '0;
        cfg_if.data        = '0;
        pix_in_if.valid    = 1'b0;
        pix_in_if.action   = ACT_LOAD;
        pix_in_if.red_in   = '0;
        pix_in_if.green_in = '0;
        pix_in_if.blue_in  = '0;
        quiet_end          = 1'b0;
        hold_req           = 1'b0;
        idle_pct           = 20;
        sent_items         = 0;
        stream_items       = 0;
        frames_done        = 0;
        repeat (RESET_CYC) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // fetch on an empty store
        send_pixel(ACT_FETCH, 8'hFF, 8'hFF, 8'hFF);

        // extreme bytes, load while full, resize in the middle of the drain
        wait_idle();
        write_reg(REG_UNMAPPED, '1);
        write_reg(REG_IMAGE_WIDTH, 9'd2);
        write_reg(REG_IMAGE_HEIGHT, 9'd3);
        send_pixel(ACT_LOAD, 8'h00, 8'h00, 8'h00);
        send_pixel(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF);
        send_pixel(ACT_LOAD, 8'hAA, 8'h55, 8'hAA);
        send_pixel(ACT_LOAD, 8'h55, 8'hAA, 8'h55);
        send_pixel(ACT_LOAD, 8'h01, 8'h80, 8'h7F);
        send_pixel(ACT_LOAD, 8'hFE, 8'h7F, 8'h80);
        send_pixel(ACT_LOAD, 8'h12, 8'h34, 8'h56);
        repeat (2) send_pixel(ACT_FETCH, 8'h00, 8'h00, 8'h00);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 9'd2);
        repeat (3) send_pixel(ACT_FETCH, 8'h00, 8'h00, 8'h00);

        // zero and oversize registers, shrink in the middle of the load
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, 9'd0);
        write_reg(REG_IMAGE_HEIGHT, 9'd511);
        repeat (3) send_random(ACT_LOAD);
        wait_idle();
        write_reg(REG_IMAGE_HEIGHT, 9'd2);
        send_random(ACT_LOAD);
        repeat (2) send_random(ACT_FETCH);

        // widest row, drained against a long output hold-off
        run_frame(9'd511, 9'd0, 1'b1, 1'b1);

        w_sel = 9'd511;
        h_sel = 9'd0;
        while (stream_items < STREAM_ITEMS) begin
            if (stream_items > STREAM_ITEMS - QUIET_ITEMS) quiet_end = 1'b1;
            if ($urandom_range(0, 3) == 0) begin
                run_frame(w_sel, h_sel, 1'b0, 1'b0);
            end else begin
                w_sel = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 16)) :
                                                      DIM_W'($urandom_range(1, 6));
                h_sel = ($urandom_range(0, 5) == 0) ? DIM_W'($urandom_range(0, 16)) :
                                                      DIM_W'($urandom_range(1, 6));
                run_frame(w_sel, h_sel, 1'b1, 1'b0);
            end
        end

        wait_idle();
        repeat (4 * SETTLE_CYC) @(negedge i_clk);
        $display("Sent %0d pixel transfers over %0d random frames plus directed resize cases;",
                 sent_items, frames_done);
        $display("checked %0d transposed pixels, including a 256-wide row under back-pressure.",
                 checked_count);
        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
